// ===== rtl/core/qtss_pkg.sv =====
package qtss_pkg;

    // Table sizes and layout in the slot arrays
    localparam int RELIABLE_DEPTH = 4;
    localparam int LATEST_DEPTH   = 4;
    localparam int SAMPLE_DEPTH   = 4;
    localparam int BULK_DEPTH     = 4;
    localparam int MAX_LEN        = 256;

    localparam int REL_BASE   = 0;
    localparam int LAT_BASE   = REL_BASE + RELIABLE_DEPTH;
    localparam int SMP_BASE   = LAT_BASE + LATEST_DEPTH;
    localparam int BLK_BASE   = SMP_BASE + SAMPLE_DEPTH;
    localparam int SLOT_TOTAL = BLK_BASE + BULK_DEPTH;

    localparam int IDX_W = (SLOT_TOTAL > 1) ? $clog2(SLOT_TOTAL) : 1;
    localparam int CNT_W = $clog2(SLOT_TOTAL + 1);

    localparam int IN_W  = 152;
    localparam int OUT_W = 64;

    // Operation codes
    localparam logic [1:0] OP_ENQ   = 2'd0;
    localparam logic [1:0] OP_POLL  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Class codes
    localparam logic [2:0] CLS_REL  = 3'd0;
    localparam logic [2:0] CLS_LAT  = 3'd1;
    localparam logic [2:0] CLS_SMP  = 3'd2;
    localparam logic [2:0] CLS_BLK  = 3'd3;
    localparam logic [2:0] CLS_AUTO = 3'd4;

    localparam logic [1:0] QOS_REL = 2'd0;
    localparam logic [1:0] QOS_BLK = 2'd2;

    // Result status codes
    localparam logic [3:0] ST_NEW       = 4'd0;
    localparam logic [3:0] ST_REPLACED  = 4'd1;
    localparam logic [3:0] ST_EVICT_LAT = 4'd2;
    localparam logic [3:0] ST_EVICT_SMP = 4'd3;
    localparam logic [3:0] ST_REJECTED  = 4'd4;
    localparam logic [3:0] ST_FULL      = 4'd5;
    localparam logic [3:0] ST_SENT      = 4'd6;
    localparam logic [3:0] ST_IDLE      = 4'd7;
    localparam logic [3:0] ST_FLUSHED   = 4'd8;
    localparam logic [3:0] ST_NONE      = 4'd9;
    localparam logic [3:0] ST_CLEARED   = 4'd10;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_COMMIT
    } state_t;

    typedef struct packed {
        logic        ready;
        logic [11:0] length;
        logic [31:0] handle;
        logic [31:0] deadline_ms;
        logic [2:0]  priority_lvl;
        logic [1:0]  qos;
        logic        decode_ok;
        logic [2:0]  msg_class;
        logic [31:0] key;
        logic [31:0] now_ms;
        logic [1:0]  op;
    } item_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic start;
        logic step;
        logic commit;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic need_scan;
        logic scan_done;
        logic out_free;
    } dp_stat_t;

    function automatic logic [4:0] sat31(input logic [CNT_W-1:0] c);
        return (32'(c) > 32'd31) ? 5'd31 : 5'(c);
    endfunction

    function automatic logic is_table_last(input logic [IDX_W-1:0] i);
        return (32'(i) == LAT_BASE - 1) || (32'(i) == SMP_BASE - 1) ||
               (32'(i) == BLK_BASE - 1) || (32'(i) == SLOT_TOTAL - 1);
    endfunction

endpackage

// ===== rtl/core/qtss_ctrl.sv =====
module qtss_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  qtss_pkg::dp_stat_t stat,
    output qtss_pkg::dp_cmd_t  cmd
);
    import qtss_pkg::*;

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.start  = 1'b1;
                state_next = stat.need_scan ? S_SCAN : S_COMMIT;
            end
            S_SCAN:
            begin
                cmd.step = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/qtss_dp.sv =====
module qtss_dp (
    input  logic                      clk,
    input  logic                      rst_n,
    input  qtss_pkg::item_t           item,
    input  qtss_pkg::dp_cmd_t         cmd,
    output qtss_pkg::dp_stat_t        stat,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [qtss_pkg::OUT_W-1:0] out_data
);
    import qtss_pkg::*;

    // Slot store
    logic [SLOT_TOTAL-1:0] used_reg, used_next;
    logic [31:0] key_mem   [SLOT_TOTAL];
    logic [31:0] order_mem [SLOT_TOTAL];
    logic [2:0]  pri_mem   [SLOT_TOTAL];
    logic [31:0] dl_mem    [SLOT_TOTAL];
    logic        hasdl_mem [SLOT_TOTAL];
    logic [31:0] hdl_mem   [SLOT_TOTAL];
    logic [11:0] len_mem   [SLOT_TOTAL];

    logic [31:0] order_reg;
    item_t       it_reg;

    // Scan trackers
    logic [IDX_W-1:0] idx_reg, idx_next, last_reg;
    logic             free_f_reg, key_f_reg, old_f_reg, cand_f_reg;
    logic [IDX_W-1:0] free_i_reg, key_i_reg, old_i_reg, cand_i_reg;
    logic [31:0]      old_o_reg, cand_o_reg;
    logic [2:0]       cand_p_reg;
    logic [31:0]      cand_h_reg;
    logic [11:0]      cand_l_reg;
    logic [CNT_W-1:0] exp_reg, cnt_reg;

    // Output register
    logic             ov_reg;
    logic [OUT_W-1:0] od_reg;

    // Resolved class and checks
    logic [2:0]       rcls;
    logic             bad;
    logic [IDX_W-1:0] base, last;
    logic             pending;

    always_comb
    begin
        rcls = it_reg.msg_class;
        if (it_reg.msg_class == CLS_AUTO)
        begin
            rcls = (it_reg.qos == QOS_REL) ? CLS_REL :
                   (it_reg.qos == QOS_BLK) ? CLS_BLK : CLS_LAT;
        end
        bad = (it_reg.length == 12'd0) || (32'(it_reg.length) > MAX_LEN) ||
              !it_reg.decode_ok;
        case (rcls)
            CLS_REL: begin base = IDX_W'(REL_BASE); last = IDX_W'(LAT_BASE - 1); end
            CLS_LAT: begin base = IDX_W'(LAT_BASE); last = IDX_W'(SMP_BASE - 1); end
            CLS_SMP: begin base = IDX_W'(SMP_BASE); last = IDX_W'(BLK_BASE - 1); end
            default: begin base = IDX_W'(BLK_BASE); last = IDX_W'(SLOT_TOTAL - 1); end
        endcase
        if (it_reg.op == OP_POLL)
        begin
            base = '0;
            last = IDX_W'(SLOT_TOTAL - 1);
        end
        pending = |used_reg;
    end

    logic scan_done;

    assign stat.need_scan = (it_reg.op == OP_ENQ && !bad && rcls < CLS_AUTO) ||
                            (it_reg.op == OP_POLL && pending && it_reg.ready);
    assign stat.out_free  = !ov_reg || out_ready;
    assign stat.scan_done = scan_done;

    // One scan step at idx_reg
    logic        u, expd, live, by_pri, take;
    logic [31:0] age;
    always_comb
    begin
        u      = used_reg[idx_reg];
        age    = it_reg.now_ms - dl_mem[idx_reg];
        expd   = u && hasdl_mem[idx_reg] && !age[31];
        live   = u && !expd;
        by_pri = 32'(idx_reg) < SMP_BASE;
        take   = live && (!cand_f_reg ||
                 (by_pri && pri_mem[idx_reg] > cand_p_reg) ||
                 (pri_mem[idx_reg] == cand_p_reg && order_mem[idx_reg] < cand_o_reg));
        idx_next = idx_reg + IDX_W'(1);
        if (it_reg.op == OP_POLL)
        begin
            scan_done = (idx_reg == last_reg) ||
                        (is_table_last(idx_reg) && (cand_f_reg || take));
        end
        else
        begin
            scan_done = (idx_reg == last_reg);
        end
    end

    // Commit decision
    logic             wr_en, send;
    logic [IDX_W-1:0] wr_i;
    logic [3:0]       st;
    logic [4:0]       ex_o, fl_o;
    always_comb
    begin
        wr_en = 1'b0;
        send  = 1'b0;
        wr_i  = free_i_reg;
        st    = ST_IDLE;
        ex_o  = 5'd0;
        fl_o  = 5'd0;
        case (it_reg.op)
            OP_ENQ:
            begin
                if (bad)
                begin
                    st = ST_REJECTED;
                end
                else
                begin
                    st = ST_FULL;
                    case (rcls)
                        CLS_REL, CLS_BLK:
                        begin
                            if (free_f_reg)
                            begin
                                wr_en = 1'b1;
                                st    = ST_NEW;
                            end
                        end
                        CLS_LAT:
                        begin
                            wr_en = 1'b1;
                            if (key_f_reg)
                            begin
                                wr_i = key_i_reg;
                                st   = ST_REPLACED;
                            end
                            else if (free_f_reg)
                            begin
                                st = ST_NEW;
                            end
                            else
                            begin
                                wr_i = old_i_reg;
                                st   = ST_EVICT_LAT;
                            end
                        end
                        CLS_SMP:
                        begin
                            wr_en = 1'b1;
                            if (free_f_reg)
                            begin
                                st = ST_NEW;
                            end
                            else
                            begin
                                wr_i = old_i_reg;
                                st   = ST_EVICT_SMP;
                            end
                        end
                        default:
                        begin
                            st = ST_FULL;
                        end
                    endcase
                end
            end
            OP_POLL:
            begin
                if (cnt_reg == '0)
                begin
                    st = ST_IDLE;
                end
                else if (!it_reg.ready)
                begin
                    st   = ST_FLUSHED;
                    fl_o = sat31(cnt_reg);
                end
                else
                begin
                    send = cand_f_reg;
                    st   = cand_f_reg ? ST_SENT : ST_NONE;
                    ex_o = sat31(exp_reg);
                end
            end
            OP_CLEAR:
            begin
                st = ST_CLEARED;
            end
            default:
            begin
                st = ST_IDLE;
            end
        endcase
    end

    // Used bits
    always_comb
    begin
        used_next = used_reg;
        if (cmd.step && it_reg.op == OP_POLL && expd)
        begin
            used_next[idx_reg] = 1'b0;
        end
        if (cmd.commit)
        begin
            if (wr_en)
            begin
                used_next[wr_i] = 1'b1;
            end
            if (send)
            begin
                used_next[cand_i_reg] = 1'b0;
            end
            if (it_reg.op == OP_CLEAR || (it_reg.op == OP_POLL && !it_reg.ready))
            begin
                used_next = '0;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= '0;
            order_reg <= 32'd1;
            ov_reg    <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
            if (cmd.commit)
            begin
                if (wr_en)
                begin
                    order_reg <= order_reg + 32'd1;
                end
                if (it_reg.op == OP_CLEAR)
                begin
                    order_reg <= 32'd1;
                end
            end
            if (cmd.commit)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    // Payload, slot fields and scan trackers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            it_reg <= item;
        end
        if (cmd.start)
        begin
            idx_reg    <= base;
            last_reg   <= last;
            free_f_reg <= 1'b0;
            key_f_reg  <= 1'b0;
            old_f_reg  <= 1'b0;
            cand_f_reg <= 1'b0;
            exp_reg    <= '0;
            cnt_reg    <= CNT_W'($countones(used_reg));
        end
        if (cmd.step)
        begin
            idx_reg <= idx_next;
            if (it_reg.op == OP_POLL)
            begin
                if (expd)
                begin
                    exp_reg <= exp_reg + CNT_W'(1);
                end
                if (take)
                begin
                    cand_f_reg <= 1'b1;
                    cand_i_reg <= idx_reg;
                    cand_p_reg <= pri_mem[idx_reg];
                    cand_o_reg <= order_mem[idx_reg];
                    cand_h_reg <= hdl_mem[idx_reg];
                    cand_l_reg <= len_mem[idx_reg];
                end
            end
            else
            begin
                if (!u && !free_f_reg)
                begin
                    free_f_reg <= 1'b1;
                    free_i_reg <= idx_reg;
                end
                if (u && !key_f_reg && key_mem[idx_reg] == it_reg.key)
                begin
                    key_f_reg <= 1'b1;
                    key_i_reg <= idx_reg;
                end
                if (u && (!old_f_reg || order_mem[idx_reg] < old_o_reg))
                begin
                    old_f_reg <= 1'b1;
                    old_i_reg <= idx_reg;
                    old_o_reg <= order_mem[idx_reg];
                end
            end
        end
        if (cmd.commit && wr_en)
        begin
            key_mem[wr_i]   <= it_reg.key;
            order_mem[wr_i] <= order_reg;
            pri_mem[wr_i]   <= it_reg.priority_lvl;
            dl_mem[wr_i]    <= it_reg.now_ms + it_reg.deadline_ms;
            hasdl_mem[wr_i] <= it_reg.deadline_ms != 32'd0;
            hdl_mem[wr_i]   <= it_reg.handle;
            len_mem[wr_i]   <= it_reg.length;
        end
        if (cmd.commit)
        begin
            od_reg <= {5'd0, fl_o, ex_o,
                       send ? cand_l_reg : 12'd0,
                       send ? cand_h_reg : 32'd0,
                       send, st};
        end
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;

endmodule

// ===== rtl/core/qos_transmit_slot_scheduler_unit.sv =====
// Transmit slot scheduler for four message classes.
// Input stream (s_axis): one beat is one command: enqueue a descriptor, poll
// for the next message to send, or clear all slots. Output stream (m_axis):
// exactly one result beat per command, in command order.
// Each command runs: take the beat, check it, scan one slot per cycle, and
// commit the result. An enqueue scans its own class table (4 slots); a poll
// scans the tables in class order and stops after the first table holding a
// live entry (up to 16 slots). Idle, rejected, offline and clear commands
// skip the scan.
// s_axis_tready is high only while no command is in progress.
// A result waits in the output register while the receiver stalls; the next
// command is still taken and processed, and only its commit waits for the
// output register to drain.
// Reset empties every slot and restarts the arrival order at one.
module qos_transmit_slot_scheduler_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // op, now_ms, msg_key, msg_class, decode_ok, policy_qos, policy_priority,
    // policy_deadline_ms, payload_handle, payload_length, transport_ready
    input  logic [qtss_pkg::IN_W-1:0]   s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // status, out_valid, out_handle, out_length, expired_count,
    // flushed_count, zero pad
    output logic [qtss_pkg::OUT_W-1:0]  m_axis_tdata
);
    import qtss_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    item_t    item;

    assign item = item_t'(s_axis_tdata);

    qtss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    qtss_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

// ===== rtl/core/qtss_checker.sv =====
module qtss_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_axis_tvalid,
    input logic                       s_axis_tready,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [qtss_pkg::OUT_W-1:0] m_axis_tdata
);
    import qtss_pkg::*;

    // Stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat dropped or changed under stall");

    // A taken command keeps the input closed in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input reopened right after a command");

    // A send flag only comes with a sent status
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[4] |-> m_axis_tdata[3:0] == ST_SENT)
        else $error("send flag without sent status");

    // No message fields when nothing is sent
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[4] |-> m_axis_tdata[48:5] == '0)
        else $error("message fields set without a send");

endmodule

bind qos_transmit_slot_scheduler_unit qtss_checker u_qtss_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
